// ----- hw/rtl/swec_pkg.sv -----
package swec_pkg;

    // Fixed field widths
    localparam int CLASS_W       = 6;
    localparam int CNT_W         = 32;
    localparam int NUM_COUNTERS  = 6;
    localparam int FLAGS_W       = 5;
    localparam int EXT_W         = 2 * CNT_W;
    // Wide enough to hold the largest class count (256)
    localparam int CLASS_LIMIT_W = 9;

    localparam int NUM_CLASSES_DEF = 64;

    // Counter slots inside a snapshot
    localparam int C_LM_BEFORE = 0;
    localparam int C_LM_AFTER  = 1;
    localparam int C_L0_BEFORE = 2;
    localparam int C_L0_AFTER  = 3;
    localparam int C_L1_BEFORE = 4;
    localparam int C_L1_AFTER  = 5;

    typedef logic [NUM_COUNTERS-1:0][CNT_W-1:0] cnt_vec_t;

    // Request as it travels from the front part to the back part
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic               in_range;
        cnt_vec_t           raw;
    } item_t;

    // Per-class stored row: previous raw values and wrap counts
    typedef struct packed {
        cnt_vec_t prev;
        cnt_vec_t wraps;
    } row_t;

    localparam int ROW_W = $bits(row_t);

endpackage

// ----- hw/rtl/swec_if.sv -----
interface swec_in_if;
    import swec_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] class_index;
    logic [CNT_W-1:0]   raw_lm_before;
    logic [CNT_W-1:0]   raw_lm_after;
    logic [CNT_W-1:0]   raw_l0_before;
    logic [CNT_W-1:0]   raw_l0_after;
    logic [CNT_W-1:0]   raw_l1_before;
    logic [CNT_W-1:0]   raw_l1_after;

    modport source (
        output valid, class_index, raw_lm_before, raw_lm_after,
               raw_l0_before, raw_l0_after, raw_l1_before, raw_l1_after,
        input  ready
    );

    modport sink (
        input  valid, class_index, raw_lm_before, raw_lm_after,
               raw_l0_before, raw_l0_after, raw_l1_before, raw_l1_after,
        output ready
    );
endinterface

interface swec_out_if;
    import swec_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] out_class;
    logic [EXT_W-1:0]   ext_lm_before;
    logic [EXT_W-1:0]   ext_lm_after;
    logic [EXT_W-1:0]   ext_l0_before;
    logic [EXT_W-1:0]   ext_l0_after;
    logic [EXT_W-1:0]   ext_l1_before;
    logic [EXT_W-1:0]   ext_l1_after;
    logic [FLAGS_W-1:0] check_flags;

    modport source (
        output valid, out_class, ext_lm_before, ext_lm_after, ext_l0_before,
               ext_l0_after, ext_l1_before, ext_l1_after, check_flags,
        input  ready
    );

    modport sink (
        input  valid, out_class, ext_lm_before, ext_lm_after, ext_l0_before,
               ext_l0_after, ext_l1_before, ext_l1_after, check_flags,
        output ready
    );
endinterface

// ----- hw/rtl/swec_ram.sv -----
module swec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; a same-address write returns the old data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/swec_front.sv -----
module swec_front import swec_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    swec_in_if.sink       snap,
    output logic          q_valid,
    output item_t         q_item,
    input  logic          q_pop
);

    localparam int Q_DEPTH = 2;

    item_t      entry_reg [Q_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      new_item;

    // Classify the incoming request
    always_comb
    begin
        new_item.cls      = snap.class_index;
        new_item.in_range = CLASS_LIMIT_W'(snap.class_index)
                            < CLASS_LIMIT_W'(NUM_CLASSES);
        new_item.raw[C_LM_BEFORE] = snap.raw_lm_before;
        new_item.raw[C_LM_AFTER]  = snap.raw_lm_after;
        new_item.raw[C_L0_BEFORE] = snap.raw_l0_before;
        new_item.raw[C_L0_AFTER]  = snap.raw_l0_after;
        new_item.raw[C_L1_BEFORE] = snap.raw_l1_before;
        new_item.raw[C_L1_AFTER]  = snap.raw_l1_after;
    end

    assign snap.ready = (count_reg != 2'(Q_DEPTH));
    assign push       = snap.valid && snap.ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = entry_reg[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- hw/rtl/swec_back.sv -----
module swec_back import swec_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  item_t         q_item,
    output logic          q_pop,
    swec_out_if.source    result
);

    localparam int ADDR_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    // Work stage
    logic                 b_valid_reg;
    item_t                b_item_reg;
    logic                 fwd_hit_reg;
    row_t                 fwd_row_reg;
    logic [NUM_CLASSES-1:0] seen_reg;

    // Output register
    logic                 out_valid_reg;
    logic [CLASS_W-1:0]   out_class_reg;
    logic [NUM_COUNTERS-1:0][EXT_W-1:0] out_ext_reg;
    logic [FLAGS_W-1:0]   out_flags_reg;

    logic                 b_adv;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [ADDR_W-1:0]    raddr;
    logic [ROW_W-1:0]     rdata;
    row_t                 row;
    row_t                 new_row;
    logic                 seen;
    cnt_vec_t             delta;
    logic [NUM_COUNTERS-1:0][EXT_W-1:0] ext;
    logic [FLAGS_W-1:0]   flags;

    assign b_adv = b_valid_reg && (!out_valid_reg || result.ready);
    assign q_pop = q_valid && (!b_valid_reg || b_adv);
    assign we    = b_adv && b_item_reg.in_range;
    assign waddr = ADDR_W'(b_item_reg.cls);
    assign raddr = ADDR_W'(q_item.cls);

    swec_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_CLASSES)
    ) u_row_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (new_row),
        .re    (q_pop),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Wrap detection, extension and delta checks
    always_comb
    begin
        row  = fwd_hit_reg ? fwd_row_reg : row_t'(rdata);
        seen = b_item_reg.in_range && seen_reg[waddr];
        for (int j = 0; j < NUM_COUNTERS; j++)
        begin
            new_row.prev[j]  = b_item_reg.raw[j];
            new_row.wraps[j] = seen ? (row.wraps[j]
                               + CNT_W'(b_item_reg.raw[j] < row.prev[j]))
                               : '0;
            delta[j]         = b_item_reg.raw[j] - row.prev[j];
            ext[j]           = {new_row.wraps[j], b_item_reg.raw[j]};
        end
        flags[0] = delta[C_LM_AFTER]  > delta[C_LM_BEFORE];
        flags[1] = delta[C_L0_AFTER]  > delta[C_L0_BEFORE];
        flags[2] = delta[C_L1_AFTER]  > delta[C_L1_BEFORE];
        flags[3] = delta[C_L0_BEFORE] > delta[C_LM_AFTER];
        flags[4] = delta[C_L1_BEFORE] > delta[C_L0_AFTER];
        if (!seen)
        begin
            flags = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (we)
            begin
                seen_reg[waddr] <= 1'b1;
            end
        end
    end

    // Payload; forward a row written in the same cycle as its read
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_item_reg  <= q_item;
            fwd_hit_reg <= we && (waddr == raddr);
            fwd_row_reg <= new_row;
        end
        if (b_adv)
        begin
            out_class_reg <= b_item_reg.cls;
            out_ext_reg   <= ext;
            out_flags_reg <= flags;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_class     = out_class_reg;
    assign result.ext_lm_before = out_ext_reg[C_LM_BEFORE];
    assign result.ext_lm_after  = out_ext_reg[C_LM_AFTER];
    assign result.ext_l0_before = out_ext_reg[C_L0_BEFORE];
    assign result.ext_l0_after  = out_ext_reg[C_L0_AFTER];
    assign result.ext_l1_before = out_ext_reg[C_L1_BEFORE];
    assign result.ext_l1_after  = out_ext_reg[C_L1_AFTER];
    assign result.check_flags   = out_flags_reg;

endmodule

// ----- hw/rtl/scaler_wrap_extender_checker.sv -----
// Trigger-counter wrap extender and checker.
// Requests arrive on snap: one class's snapshot of six free-running 32-bit
// counters. Each request produces exactly one response on result: the class,
// six 64-bit extended counts (raw value with the class's wrap count on top)
// and five flags comparing per-stage increases since the class's last request.
// Classes at or above NUM_CLASSES pass through with zero wraps and no flags.
// Throughput: one request per cycle while the receiver keeps up. Each request
// passes through the two-entry queue, then the row-memory read into the work
// stage, then the output register. The per-class row memory is read and
// written back once per request; a back-to-back request to the same class picks
// up the row being written through a forwarding path.
// Reset clears the seen bits, so every class starts over with zero wraps and
// its first request gives zero flags; the row memory needs no clearing.
// When the receiver stalls, the output register holds its response, the work
// stage and queue fill, and snap.ready drops once the queue is full.
module scaler_wrap_extender_checker import swec_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    swec_in_if.sink    snap,
    swec_out_if.source result
);

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    swec_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .snap    (snap),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    swec_back #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

// ----- verif/tb.sv -----
module tb;
    import swec_pkg::*;

    localparam int NUM_CLS      = NUM_CLASSES_DEF;
    localparam int RANDOM_SNAPS = 1400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;

    // Flag bit positions in check_flags
    localparam int FLAG_LM_VETO  = 0;
    localparam int FLAG_L0_VETO  = 1;
    localparam int FLAG_L1_VETO  = 2;
    localparam int FLAG_L0_ABOVE = 3;
    localparam int FLAG_L1_ABOVE = 4;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        cnt_vec_t           raw;
    } snap_t;

    typedef struct packed {
        logic [CLASS_W-1:0]                 cls;
        logic [NUM_COUNTERS-1:0][EXT_W-1:0] ext;
        logic [FLAGS_W-1:0]                 flags;
    } ext_result_t;

    logic clk;
    logic rst_n;

    swec_in_if  snap ();
    swec_out_if result ();

    scaler_wrap_extender_checker #(
        .NUM_CLASSES(NUM_CLS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .snap   (snap),
        .result (result)
    );

    // Predictor state: last raw values, wrap counts, seen bits per class
    logic [CNT_W-1:0] last_raw  [NUM_CLS][NUM_COUNTERS];
    logic [CNT_W-1:0] wrap_cnt  [NUM_CLS][NUM_COUNTERS];
    logic             class_hit [NUM_CLS];

    // Stimulus generator: running counter values per class
    cnt_vec_t gen_count [NUM_CLS];

    snap_t       pending_snaps [$];
    ext_result_t extended_q [$];

    int  total_snaps;
    int  snaps_accepted;
    int  mismatches;
    int  quiet_cycles;
    logic snap_taken;

    function automatic cnt_vec_t counts6(input logic [CNT_W-1:0] lmb, lma, l0b, l0a, l1b, l1a);
        cnt_vec_t v;
        v[C_LM_BEFORE] = lmb;
        v[C_LM_AFTER]  = lma;
        v[C_L0_BEFORE] = l0b;
        v[C_L0_AFTER]  = l0a;
        v[C_L1_BEFORE] = l1b;
        v[C_L1_AFTER]  = l1a;
        return v;
    endfunction

    // Expected response for one accepted request; updates the per-class state
    function automatic ext_result_t predict_extension(input snap_t s);
        ext_result_t r;
        logic [CNT_W-1:0] delta [NUM_COUNTERS];
        int c;
        int j;
        r.cls   = s.cls;
        r.flags = '0;
        c       = int'(s.cls);
        for (j = 0; j < NUM_COUNTERS; j++)
        begin
            delta[j] = '0;
        end
        if (c < NUM_CLS)
        begin
            if (class_hit[c])
            begin
                for (j = 0; j < NUM_COUNTERS; j++)
                begin
                    if (s.raw[j] < last_raw[c][j])
                    begin
                        wrap_cnt[c][j] = wrap_cnt[c][j] + 1'b1;
                    end
                    delta[j] = s.raw[j] - last_raw[c][j];
                end
                r.flags[FLAG_LM_VETO]  = delta[C_LM_AFTER]  > delta[C_LM_BEFORE];
                r.flags[FLAG_L0_VETO]  = delta[C_L0_AFTER]  > delta[C_L0_BEFORE];
                r.flags[FLAG_L1_VETO]  = delta[C_L1_AFTER]  > delta[C_L1_BEFORE];
                r.flags[FLAG_L0_ABOVE] = delta[C_L0_BEFORE] > delta[C_LM_AFTER];
                r.flags[FLAG_L1_ABOVE] = delta[C_L1_BEFORE] > delta[C_L0_AFTER];
            end
            for (j = 0; j < NUM_COUNTERS; j++)
            begin
                last_raw[c][j] = s.raw[j];
                r.ext[j]       = {wrap_cnt[c][j], s.raw[j]};
            end
            class_hit[c] = 1'b1;
        end
        else
        begin
            for (j = 0; j < NUM_COUNTERS; j++)
            begin
                r.ext[j] = {{CNT_W{1'b0}}, s.raw[j]};
            end
        end
        return r;
    endfunction

    task automatic queue_snap(input logic [CLASS_W-1:0] cls, input cnt_vec_t raw);
        snap_t s;
        s.cls          = cls;
        s.raw          = raw;
        gen_count[cls] = raw;
        pending_snaps.insert(pending_snaps.size(), s);
    endtask

    // Advance each counter of a class by the given increase (mod 2^32)
    task automatic queue_step(input logic [CLASS_W-1:0] cls, input cnt_vec_t incr);
        cnt_vec_t raw;
        int j;
        for (j = 0; j < NUM_COUNTERS; j++)
        begin
            raw[j] = gen_count[cls][j] + incr[j];
        end
        queue_snap(cls, raw);
    endtask

    task automatic check_field(input string what, input logic [EXT_W-1:0] want, got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Idle percentage per phase: sender light / receiver heavy, then swapped, then none
    function automatic int idle_pct(input bit sender);
        if (snaps_accepted < total_snaps / 3)
            return sender ? 11 : 71;
        else if (snaps_accepted < (2 * total_snaps) / 3)
            return sender ? 71 : 11;
        else
            return 0;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Request driver: changes inputs at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!snap.valid || snap_taken)
            begin
                if (pending_snaps.size() > 0 && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    snap.class_index   <= pending_snaps[0].cls;
                    snap.raw_lm_before <= pending_snaps[0].raw[C_LM_BEFORE];
                    snap.raw_lm_after  <= pending_snaps[0].raw[C_LM_AFTER];
                    snap.raw_l0_before <= pending_snaps[0].raw[C_L0_BEFORE];
                    snap.raw_l0_after  <= pending_snaps[0].raw[C_L0_AFTER];
                    snap.raw_l1_before <= pending_snaps[0].raw[C_L1_BEFORE];
                    snap.raw_l1_after  <= pending_snaps[0].raw[C_L1_AFTER];
                    snap.valid         <= 1'b1;
                    void'(pending_snaps.pop_front());
                end
                else
                begin
                    snap.valid <= 1'b0;
                end
            end
            result.ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Monitor: predict on accepted requests, check accepted responses
    always @(posedge clk)
    begin
        snap_t       s;
        ext_result_t want;
        if (!rst_n)
        begin
            snap_taken <= 1'b0;
        end
        else
        begin
            snap_taken <= snap.valid && snap.ready;
            if (snap.valid && snap.ready)
            begin
                s.cls = snap.class_index;
                s.raw = counts6(snap.raw_lm_before, snap.raw_lm_after, snap.raw_l0_before,
                                snap.raw_l0_after, snap.raw_l1_before, snap.raw_l1_after);
                extended_q.insert(extended_q.size(), predict_extension(s));
                snaps_accepted++;
            end
            if (result.valid && result.ready)
            begin
                if (extended_q.size() == 0)
                begin
                    $display("%0t: unexpected response: expected none, actual class %0d",
                             $time, result.out_class);
                    mismatches++;
                end
                else
                begin
                    want = extended_q.pop_front();
                    check_field("out_class", EXT_W'(want.cls), EXT_W'(result.out_class));
                    check_field("ext_lm_before", want.ext[C_LM_BEFORE], result.ext_lm_before);
                    check_field("ext_lm_after", want.ext[C_LM_AFTER], result.ext_lm_after);
                    check_field("ext_l0_before", want.ext[C_L0_BEFORE], result.ext_l0_before);
                    check_field("ext_l0_after", want.ext[C_L0_AFTER], result.ext_l0_after);
                    check_field("ext_l1_before", want.ext[C_L1_BEFORE], result.ext_l1_before);
                    check_field("ext_l1_after", want.ext[C_L1_AFTER], result.ext_l1_after);
                    check_field("check_flags", EXT_W'(want.flags), EXT_W'(result.check_flags));
                end
            end
        end
    end

    // Watchdog: no handshake on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((snap.valid && snap.ready) || (result.valid && result.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL scaler_wrap_extender_checker");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int c;
        int j;
        int sel;
        logic [CLASS_W-1:0] cls;
        logic [CNT_W-1:0]   base;
        cnt_vec_t           incr;
        cnt_vec_t           raw;

        rst_n              = 1'b0;
        snap.valid         = 1'b0;
        snap.class_index   = '0;
        snap.raw_lm_before = '0;
        snap.raw_lm_after  = '0;
        snap.raw_l0_before = '0;
        snap.raw_l0_after  = '0;
        snap.raw_l1_before = '0;
        snap.raw_l1_after  = '0;
        result.ready       = 1'b0;
        snap_taken         = 1'b0;
        snaps_accepted     = 0;
        mismatches         = 0;
        quiet_cycles       = 0;
        for (c = 0; c < NUM_CLS; c++)
        begin
            class_hit[c] = 1'b0;
            gen_count[c] = '0;
            for (j = 0; j < NUM_COUNTERS; j++)
            begin
                last_raw[c][j] = '0;
                wrap_cnt[c][j] = '0;
            end
        end

        // Directed: first request of a class, extremes, wrap on every counter
        queue_snap(CLASS_W'(0), '0);
        queue_snap(CLASS_W'(0), '1);
        queue_snap(CLASS_W'(0), '0);
        queue_snap(CLASS_W'(63), '1);
        queue_step(CLASS_W'(63), counts6(1, 1, 1, 1, 1, 1));
        queue_step(CLASS_W'(63), counts6(1, 2, 3, 4, 5, 6));
        // One flag at a time on a single class, then no increase at all
        queue_snap(CLASS_W'(1), counts6(100, 200, 300, 400, 500, 600));
        queue_step(CLASS_W'(1), counts6(5, 6, 4, 3, 2, 1));
        queue_step(CLASS_W'(1), counts6(9, 8, 7, 8, 6, 5));
        queue_step(CLASS_W'(1), counts6(9, 8, 7, 6, 5, 6));
        queue_step(CLASS_W'(1), counts6(9, 8, 9, 8, 7, 6));
        queue_step(CLASS_W'(1), counts6(9, 8, 7, 6, 7, 6));
        queue_step(CLASS_W'(1), '0);
        // Largest and zero increases, wrap on alternate counters
        queue_snap(CLASS_W'(2), {NUM_COUNTERS{32'h8000_0000}});
        queue_step(CLASS_W'(2), counts6('1, 0, '1, 0, '1, 0));
        queue_step(CLASS_W'(2), counts6(0, '1, 0, '1, 0, '1));
        // Interleaved classes
        queue_step(CLASS_W'(1), counts6(32'hffff_ff00, 3, 2, 1, 0, 0));
        queue_step(CLASS_W'(2), counts6(7, 7, 7, 7, 7, 7));
        queue_step(CLASS_W'(1), counts6(1000, 900, 800, 700, 600, 500));

        // Random: mostly plausible counter progressions, some noise
        for (n = 0; n < RANDOM_SNAPS; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
                cls = CLASS_W'($urandom_range(3));
            else if (sel < 50)
                cls = CLASS_W'(NUM_CLS - 1 - $urandom_range(1));
            else
                cls = CLASS_W'($urandom_range(NUM_CLS - 1));

            sel = $urandom_range(99);
            if (sel < 10)
            begin
                for (j = 0; j < NUM_COUNTERS; j++)
                begin
                    raw[j] = $urandom;
                end
                queue_snap(cls, raw);
            end
            else
            begin
                sel = $urandom_range(99);
                if (sel < 60)
                    base = $urandom_range(1000);
                else if (sel < 85)
                    base = $urandom & 32'h00ff_ffff;
                else
                    base = $urandom;
                incr[0] = base;
                // Each stage usually counts no more than the one before it
                for (j = 1; j < NUM_COUNTERS; j++)
                begin
                    if ($urandom_range(3) == 0)
                        incr[j] = incr[j-1] + $urandom_range(50);
                    else
                        incr[j] = incr[j-1] - $urandom_range(incr[j-1]);
                end
                queue_step(cls, incr);
            end
        end
        total_snaps = pending_snaps.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_snaps.size() > 0 || snap.valid || extended_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && extended_q.size() == 0)
        begin
            $display("PASS scaler_wrap_extender_checker");
        end
        else
        begin
            $display("FAIL scaler_wrap_extender_checker");
        end
        $finish;
    end

endmodule
